// ===== rtl/core/wttn_pkg.sv =====
// Shared types and constants for the wait table with notification FIFO.
package wttn_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int FIFO_DEPTH  = 16;
    localparam int TIDX_W      = $clog2(TABLE_DEPTH);
    localparam int FIDX_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int KEY_W       = 16;
    localparam int SLOT_W      = 4;
    localparam int KIND_W      = 2;
    localparam int OP_W        = 3;
    localparam int IN_W        = 103;
    localparam int IN_BUS_W    = 104;
    localparam int OUT_W       = 106;
    localparam int OUT_BUS_W   = 112;

    localparam logic [KIND_W-1:0] KIND_FREE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_FIND    = 3'd1,
        OP_NOTIFY  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_POP     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_TABLE_FULL = 3'd1,
        STAT_NO_MATCH   = 3'd2,
        STAT_FIFO_FULL  = 3'd3,
        STAT_FIFO_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic [SLOT_W-1:0] start_index;
        logic              file_dir;
        logic [15:0]       file_count;
        logic [15:0]       file_dest;
        logic [15:0]       file_desc;
        logic [15:0]       syscall_ref;
        logic [KIND_W-1:0] wait_kind;
        logic [KEY_W-1:0]  trigger_key;
        logic [15:0]       pid;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]  popped_key;
        logic              found_file_dir;
        logic [15:0]       found_file_count;
        logic [15:0]       found_file_dest;
        logic [15:0]       found_file_desc;
        logic [15:0]       found_syscall_ref;
        logic [KIND_W-1:0] found_kind;
        logic [15:0]       found_pid;
        logic [SLOT_W-1:0] slot_index;
        status_t           status;
    } out_word_t;

    typedef struct packed {
        logic [15:0]      pid;
        logic [KEY_W-1:0] trigger;
        logic [15:0]      syscall;
    } slot_main_t;

    typedef struct packed {
        logic        dir;
        logic [15:0] count;
        logic [15:0] dest;
        logic [15:0] desc;
    } slot_file_t;

    typedef struct packed {
        logic              add_en;
        logic              file_en;
        logic [TIDX_W-1:0] add_idx;
        logic [KIND_W-1:0] add_kind;
        slot_main_t        main_wr;
        slot_file_t        file_wr;
        logic              rel_en;
        logic [TIDX_W-1:0] rel_idx;
        logic [TIDX_W-1:0] rd_idx;
    } tbl_req_t;

    typedef struct packed {
        logic              free_any;
        logic [TIDX_W-1:0] free_idx;
        logic [KIND_W-1:0] rd_kind;
        slot_main_t        rd_main;
        slot_file_t        rd_file;
    } tbl_rsp_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } fifo_req_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [KEY_W-1:0] rd_key;
    } fifo_rsp_t;

endpackage

// ===== rtl/core/wttn_table.sv =====
// Waiter slot storage: kind flops, slot memories and lowest-free-slot encoder.
module wttn_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  wttn_pkg::tbl_req_t req,
    output wttn_pkg::tbl_rsp_t rsp
);
    import wttn_pkg::*;

    logic [KIND_W-1:0] kind_reg [TABLE_DEPTH];
    slot_main_t        main_mem [TABLE_DEPTH];
    slot_file_t        file_mem [TABLE_DEPTH];
    slot_main_t        main_rd_reg;
    slot_file_t        file_rd_reg;
    logic [KIND_W-1:0] kind_rd_reg;
    logic              free_any;
    logic [TIDX_W-1:0] free_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                kind_reg[i] <= KIND_FREE;
            end
        end else begin
            if (req.rel_en) begin
                kind_reg[req.rel_idx] <= KIND_FREE;
            end
            if (req.add_en) begin
                kind_reg[req.add_idx] <= req.add_kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.add_en) begin
            main_mem[req.add_idx] <= req.main_wr;
        end
        if (req.file_en) begin
            file_mem[req.add_idx] <= req.file_wr;
        end
        main_rd_reg <= main_mem[req.rd_idx];
        file_rd_reg <= file_mem[req.rd_idx];
        kind_rd_reg <= kind_reg[req.rd_idx];
    end

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (kind_reg[i] == KIND_FREE) begin
                free_any = 1'b1;
                free_idx = TIDX_W'(i);
            end
        end
    end

    assign rsp.free_any = free_any;
    assign rsp.free_idx = free_idx;
    assign rsp.rd_kind  = kind_rd_reg;
    assign rsp.rd_main  = main_rd_reg;
    assign rsp.rd_file  = file_rd_reg;

endmodule

// ===== rtl/core/wttn_fifo.sv =====
// Pending-notification FIFO: key memory with head, tail and fill count.
module wttn_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  wttn_pkg::fifo_req_t req,
    output wttn_pkg::fifo_rsp_t rsp
);
    import wttn_pkg::*;

    logic [KEY_W-1:0]  mem [FIFO_DEPTH];
    logic [FIDX_W-1:0] head_reg;
    logic [FIDX_W-1:0] tail_reg;
    logic [FCNT_W-1:0] fill_reg;
    logic [KEY_W-1:0]  rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (req.push) begin
                tail_reg <= (tail_reg == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (req.pop) begin
                head_reg <= (head_reg == FIDX_W'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (req.push && !req.pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (req.pop && !req.push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.push) begin
            mem[tail_reg] <= req.key;
        end
        if (req.pop) begin
            rd_reg <= mem[head_reg];
        end
    end

    assign rsp.full   = (fill_reg == FCNT_W'(FIFO_DEPTH));
    assign rsp.empty  = (fill_reg == '0);
    assign rsp.rd_key = rd_reg;

endmodule

// ===== rtl/core/wait_table_with_notify_fifo_unit.sv =====
// Steps: add, notify, release and unknown ops pass from idle to the result state; pop passes
// through a pop state first. Find scans slots from start_index up to the last slot, one slot
// read per cycle from the slot memories, before the result state.
// Throughput: one word at a time; the next word is taken once the result moves to the
// output register, which may still be waiting on m_tready.
// Reset: slot kinds (flops) cleared to free and FIFO pointers zeroed at once.
module wait_table_with_notify_fifo_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pid, trigger_key, wait_kind, syscall_ref, file_desc, file_dest, file_count,
    // file_dir, start_index
    input  logic [wttn_pkg::IN_BUS_W-1:0]     s_tdata,
    // op
    input  logic [wttn_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, slot_index, found_pid, found_kind, found_syscall_ref, found_file_desc,
    // found_file_dest, found_file_count, found_file_dir, popped_key
    output logic [wttn_pkg::OUT_BUS_W-1:0]    m_tdata
);
    import wttn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [TIDX_W-1:0] idx_reg, idx_next;
    out_word_t         res_reg, res_next;
    out_word_t         out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    in_word_t  in_w;
    logic      start_ok;
    tbl_req_t  tbl_req;
    tbl_rsp_t  tbl_rsp;
    fifo_req_t fifo_req;
    fifo_rsp_t fifo_rsp;

    wttn_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rsp     (tbl_rsp)
    );

    wttn_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fifo_req),
        .rsp     (fifo_rsp)
    );

    assign in_w     = in_word_t'(s_tdata[IN_W-1:0]);
    assign start_ok = (int'(in_w.start_index) < TABLE_DEPTH);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_BUS_W - OUT_W){1'b0}}, out_reg};

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        tbl_req       = '0;
        tbl_req.rd_idx = TIDX_W'(idx_reg + 1'b1);
        fifo_req      = '0;
        fifo_req.key  = in_w.trigger_key;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_next        = '0;
                    res_next.status = STAT_OK;
                    state_next      = ST_RESULT;
                    unique case (op_t'(s_tuser))
                        OP_ADD: begin
                            if (tbl_rsp.free_any) begin
                                tbl_req.add_en  = 1'b1;
                                tbl_req.file_en = (in_w.wait_kind == KIND_FILE);
                                tbl_req.add_idx = tbl_rsp.free_idx;
                                tbl_req.add_kind = in_w.wait_kind;
                                tbl_req.main_wr = '{pid: in_w.pid, trigger: in_w.trigger_key,
                                                    syscall: in_w.syscall_ref};
                                tbl_req.file_wr = '{dir: in_w.file_dir, count: in_w.file_count,
                                                    dest: in_w.file_dest, desc: in_w.file_desc};
                                res_next.slot_index = SLOT_W'(tbl_rsp.free_idx);
                            end else begin
                                res_next.status = STAT_TABLE_FULL;
                            end
                        end
                        OP_FIND: begin
                            key_next = in_w.trigger_key;
                            if (start_ok) begin
                                idx_next       = TIDX_W'(in_w.start_index);
                                tbl_req.rd_idx = TIDX_W'(in_w.start_index);
                                state_next     = ST_SCAN;
                            end else begin
                                res_next.status = STAT_NO_MATCH;
                            end
                        end
                        OP_NOTIFY: begin
                            if (fifo_rsp.full) begin
                                res_next.status = STAT_FIFO_FULL;
                            end else begin
                                fifo_req.push = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            tbl_req.rel_en  = start_ok;
                            tbl_req.rel_idx = TIDX_W'(in_w.start_index);
                        end
                        OP_POP: begin
                            if (fifo_rsp.empty) begin
                                res_next.status = STAT_FIFO_EMPTY;
                            end else begin
                                fifo_req.pop = 1'b1;
                                state_next   = ST_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (tbl_rsp.rd_kind != KIND_FREE && tbl_rsp.rd_main.trigger == key_reg) begin
                    res_next.slot_index        = SLOT_W'(idx_reg);
                    res_next.found_pid         = tbl_rsp.rd_main.pid;
                    res_next.found_kind        = tbl_rsp.rd_kind;
                    res_next.found_syscall_ref = tbl_rsp.rd_main.syscall;
                    if (tbl_rsp.rd_kind == KIND_FILE) begin
                        res_next.found_file_desc  = tbl_rsp.rd_file.desc;
                        res_next.found_file_dest  = tbl_rsp.rd_file.dest;
                        res_next.found_file_count = tbl_rsp.rd_file.count;
                        res_next.found_file_dir   = tbl_rsp.rd_file.dir;
                    end
                    state_next = ST_RESULT;
                end else if (idx_reg == TIDX_W'(TABLE_DEPTH - 1)) begin
                    res_next.status = STAT_NO_MATCH;
                    state_next      = ST_RESULT;
                end else begin
                    idx_next = TIDX_W'(idx_reg + 1'b1);
                end
            end
            ST_POP: begin
                res_next.popped_key = fifo_rsp.rd_key;
                state_next          = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg <= key_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_fifo_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_rsp.full && fifo_rsp.empty))
        else $error("fifo reports full and empty together");

    a_find_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_FIND && start_ok |=> state_reg == ST_SCAN)
        else $error("find did not start a slot scan");

    a_add_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_ADD && tbl_rsp.free_any
        |=> res_reg.status == STAT_OK)
        else $error("add reported full with a free slot");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_RESULT)
        else $error("output word loaded outside result state");
`endif

endmodule

// ===== tb/sv/wait_table_with_notify_fifo_unit_test.sv =====
// Testbench for the wait table with notification FIFO: directed and random ops against a shadow table.
module wait_table_with_notify_fifo_unit_test;
    import wttn_pkg::*;

    localparam logic [KIND_W-1:0] KIND_TIMER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CHILD  = 2'd3;
    localparam logic [OP_W-1:0]   OP_BAD_LO   = 3'd5;
    localparam logic [OP_W-1:0]   OP_BAD_HI   = 3'd7;
    localparam int                WORD_COUNT  = 1700;
    localparam int                CYCLE_LIMIT = 400000;

    // Shadow copy of the waiter slots and the notification queue.
    class wait_table_shadow;
        logic [KIND_W-1:0] kind_of [TABLE_DEPTH];
        logic [15:0]       pid_of  [TABLE_DEPTH];
        logic [KEY_W-1:0]  key_of  [TABLE_DEPTH];
        logic [15:0]       sref_of [TABLE_DEPTH];
        logic [15:0]       fd_of   [TABLE_DEPTH];
        logic [15:0]       dest_of [TABLE_DEPTH];
        logic [15:0]       cnt_of  [TABLE_DEPTH];
        logic              dir_of  [TABLE_DEPTH];
        logic [KEY_W-1:0]  notify_q [FIFO_DEPTH];
        int                q_head;
        int                q_fill;
        out_word_t         expected_replies [$];
        int                error_count;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                kind_of[i] = KIND_FREE;
                pid_of[i]  = '0;
                key_of[i]  = '0;
                sref_of[i] = '0;
                fd_of[i]   = '0;
                dest_of[i] = '0;
                cnt_of[i]  = '0;
                dir_of[i]  = 1'b0;
            end
            for (int i = 0; i < FIFO_DEPTH; i++) notify_q[i] = '0;
            q_head      = 0;
            q_fill      = 0;
            error_count = 0;
        endfunction

        function void record_request(logic [OP_W-1:0] opc, in_word_t w);
            out_word_t r;
            int        idx;
            r   = '0;
            idx = -1;
            case (opc)
                OP_ADD: begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (idx < 0 && kind_of[i] == KIND_FREE) idx = i;
                    if (idx < 0) begin
                        r.status = STAT_TABLE_FULL;
                    end else begin
                        pid_of[idx]  = w.pid;
                        key_of[idx]  = w.trigger_key;
                        kind_of[idx] = w.wait_kind;
                        sref_of[idx] = w.syscall_ref;
                        if (w.wait_kind == KIND_FILE) begin
                            fd_of[idx]   = w.file_desc;
                            dest_of[idx] = w.file_dest;
                            cnt_of[idx]  = w.file_count;
                            dir_of[idx]  = w.file_dir;
                        end
                        r.slot_index = idx[SLOT_W-1:0];
                    end
                end
                OP_FIND: begin
                    for (int i = int'(w.start_index); i < TABLE_DEPTH; i++)
                        if (idx < 0 && kind_of[i] != KIND_FREE && key_of[i] == w.trigger_key)
                            idx = i;
                    if (idx < 0) begin
                        r.status = STAT_NO_MATCH;
                    end else begin
                        r.slot_index        = idx[SLOT_W-1:0];
                        r.found_pid         = pid_of[idx];
                        r.found_kind        = kind_of[idx];
                        r.found_syscall_ref = sref_of[idx];
                        if (kind_of[idx] == KIND_FILE) begin
                            r.found_file_desc  = fd_of[idx];
                            r.found_file_dest  = dest_of[idx];
                            r.found_file_count = cnt_of[idx];
                            r.found_file_dir   = dir_of[idx];
                        end
                    end
                end
                OP_NOTIFY: begin
                    if (q_fill >= FIFO_DEPTH) begin
                        r.status = STAT_FIFO_FULL;
                    end else begin
                        notify_q[(q_head + q_fill) % FIFO_DEPTH] = w.trigger_key;
                        q_fill++;
                    end
                end
                OP_RELEASE: begin
                    if (int'(w.start_index) < TABLE_DEPTH) kind_of[w.start_index] = KIND_FREE;
                end
                OP_POP: begin
                    if (q_fill == 0) begin
                        r.status = STAT_FIFO_EMPTY;
                    end else begin
                        r.popped_key = notify_q[q_head];
                        q_head = (q_head + 1) % FIFO_DEPTH;
                        q_fill--;
                    end
                end
                default: ;
            endcase
            expected_replies.push_back(r);
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
                error_count++;
            end
        endfunction

        function void check_reply(out_word_t got);
            out_word_t want;
            if (expected_replies.size() == 0) begin
                $error("unexpected result word 0x%0h", got);
                error_count++;
                return;
            end
            want = expected_replies.pop_front();
            compare("status", want.status, got.status);
            compare("slot_index", want.slot_index, got.slot_index);
            compare("found_pid", want.found_pid, got.found_pid);
            compare("found_kind", want.found_kind, got.found_kind);
            compare("found_syscall_ref", want.found_syscall_ref, got.found_syscall_ref);
            compare("found_file_desc", want.found_file_desc, got.found_file_desc);
            compare("found_file_dest", want.found_file_dest, got.found_file_dest);
            compare("found_file_count", want.found_file_count, got.found_file_count);
            compare("found_file_dir", want.found_file_dir, got.found_file_dir);
            compare("popped_key", want.popped_key, got.popped_key);
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_BUS_W-1:0]  s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_BUS_W-1:0] m_tdata;

    wait_table_shadow shadow = new();
    bit               fast_in;
    bit               fast_out;
    int               cycle_count;

    wait_table_with_notify_fifo_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic in_word_t make_word(logic [15:0] pid, logic [KEY_W-1:0] key,
                                           logic [KIND_W-1:0] kind, logic [15:0] sref,
                                           logic [15:0] fd, logic [15:0] dest,
                                           logic [15:0] cnt, logic dir,
                                           logic [SLOT_W-1:0] start);
        in_word_t w;
        w.pid         = pid;
        w.trigger_key = key;
        w.wait_kind   = kind;
        w.syscall_ref = sref;
        w.file_desc   = fd;
        w.file_dest   = dest;
        w.file_count  = cnt;
        w.file_dir    = dir;
        w.start_index = start;
        return w;
    endfunction

    task automatic send_word(logic [OP_W-1:0] opc, in_word_t w);
        int gap;
        gap = fast_in ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w};
        s_tuser  <= opc;
        do @(posedge aclk); while (!s_tready);
        shadow.record_request(opc, w);
    endtask

    // result side; long holds fill the block and back up the input
    initial begin
        int stall;
        int got_count;
        got_count = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (got_count == 40 || got_count == 900) stall = 300;
            else if (fast_out) stall = 0;
            else stall = $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            shadow.check_reply(out_word_t'(m_tdata[OUT_W-1:0]));
            got_count++;
            if (got_count % 50 == 0) fast_out = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        in_word_t        w;
        logic [OP_W-1:0] opc;
        logic [15:0]     odd_mask;
        int              r;
        int              t_add, t_find, t_notify, t_release, t_pop;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        aresetn  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every slot with a file wait so no slot is ever read unwritten
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            odd_mask = (i % 2) ? 16'hFFFF : 16'h0000;
            send_word(OP_ADD, make_word(odd_mask ^ 16'(i), (i == 15) ? 16'hFFFF : 16'(i % 4),
                                        KIND_FILE, ~odd_mask, ~odd_mask, 16'(i * 4097),
                                        odd_mask, odd_mask[0], '0));
        end
        send_word(OP_ADD, make_word(16'h1234, 16'h0007, KIND_CHILD, '0, '0, '0, '0, 1'b0, '0));
        send_word(OP_FIND, make_word('0, 16'h0000, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd0));
        send_word(OP_FIND, make_word('0, 16'hFFFF, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd15));
        send_word(OP_FIND, make_word('0, 16'h0000, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd13));
        send_word(OP_RELEASE, make_word('0, '0, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd5));
        send_word(OP_RELEASE, make_word('0, '0, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd5));
        // timer wait keeps stale file fields, which must not show up
        send_word(OP_ADD, make_word(16'hA5A5, 16'h00AA, KIND_TIMER, 16'h5A5A,
                                    16'h1111, 16'h2222, 16'h3333, 1'b1, '0));
        send_word(OP_FIND, make_word('0, 16'h00AA, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd0));
        // kind free add leaves the slot free
        send_word(OP_RELEASE, make_word('0, '0, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd6));
        send_word(OP_ADD, make_word(16'h0BB0, 16'h00BB, KIND_FREE, 16'h0B0B,
                                    '0, '0, '0, 1'b0, '0));
        send_word(OP_FIND, make_word('0, 16'h00BB, KIND_FREE, '0, '0, '0, '0, 1'b0, 4'd0));
        send_word(OP_POP, make_word('0, '0, KIND_FREE, '0, '0, '0, '0, 1'b0, '0));
        send_word(OP_NOTIFY, make_word('0, 16'hFFFF, KIND_FREE, '0, '0, '0, '0, 1'b0, '0));
        send_word(OP_NOTIFY, make_word('0, 16'h0000, KIND_FREE, '0, '0, '0, '0, 1'b0, '0));
        send_word(OP_POP, make_word('0, '0, KIND_FREE, '0, '0, '0, '0, 1'b0, '0));
        send_word(OP_BAD_LO, make_word('1, '1, KIND_CHILD, '1, '1, '1, '1, 1'b1, '1));

        for (int n = 0; n < WORD_COUNT; n++) begin
            if (n % 64 == 0) fast_in = ($urandom_range(0, 3) == 0);
            // phases: balanced, table filling, notify burst, draining
            case ((n / 150) % 4)
                0: begin
                    t_add = 30; t_find = 55; t_notify = 70; t_release = 85; t_pop = 97;
                end
                1: begin
                    t_add = 50; t_find = 75; t_notify = 82; t_release = 88; t_pop = 97;
                end
                2: begin
                    t_add = 15; t_find = 30; t_notify = 75; t_release = 82; t_pop = 97;
                end
                default: begin
                    t_add = 15; t_find = 40; t_notify = 48; t_release = 70; t_pop = 97;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < t_add) opc = OP_ADD;
            else if (r < t_find) opc = OP_FIND;
            else if (r < t_notify) opc = OP_NOTIFY;
            else if (r < t_release) opc = OP_RELEASE;
            else if (r < t_pop) opc = OP_POP;
            else opc = OP_BAD_LO + OP_W'($urandom_range(0, OP_BAD_HI - OP_BAD_LO));

            w.pid         = 16'($urandom);
            w.trigger_key = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 5)) * 16'h3333
                                                        : 16'($urandom);
            w.wait_kind   = ($urandom_range(0, 19) == 0) ? KIND_FREE
                                                         : KIND_W'($urandom_range(1, 3));
            w.syscall_ref = 16'($urandom);
            w.file_desc   = 16'($urandom);
            w.file_dest   = 16'($urandom);
            w.file_count  = 16'($urandom);
            w.file_dir    = 1'($urandom_range(0, 1));
            w.start_index = ($urandom_range(0, 2) == 0) ? '0 : SLOT_W'($urandom_range(0, 15));
            send_word(opc, w);
        end
        s_tvalid <= 1'b0;

        while (shadow.expected_replies.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (shadow.error_count == 0 && shadow.expected_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== wait_table_with_notify_fifo_unit.f =====
rtl/core/wttn_pkg.sv
rtl/core/wttn_table.sv
rtl/core/wttn_fifo.sv
rtl/core/wait_table_with_notify_fifo_unit.sv
tb/sv/wait_table_with_notify_fifo_unit_test.sv
